// ----- sv/mlfc_pkg.sv -----
// shared types, constants and the crc-8 byte update for the motor link frame codec
// no dependencies; imported by every module of the block
`default_nettype none

package mlfc_pkg;

    localparam int unsigned REPLY_LENGTH_DEF = 10;
    localparam int unsigned STORE_DEPTH      = 9;
    localparam int unsigned CNT_W            = 4;
    localparam int unsigned IDX_W            = 3;
    localparam int unsigned PADDR_W          = 3;

    localparam logic [7:0]       CRC_POLY   = 8'h07;
    localparam logic [IDX_W-1:0] FRAME_LAST = 3'd4;

    // register index decoded from paddr[2]
    localparam logic REG_REPORT_MODE = 1'b0;

    typedef enum logic [1:0] {
        REQ_CMD     = 2'd0,
        REQ_BYTE    = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_OK      = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  addr;
        logic [7:0]  mode;
        logic [7:0]  qty_lo;
        logic [7:0]  qty_hi;
        logic [7:0]  status;
        logic [15:0] current;
        logic [15:0] speed;
        logic [15:0] angle;
    } grp_t;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mlfc_cfg.sv -----
// apb-style configuration register holding the report mode code
// depends on mlfc_pkg
`default_nettype none

module mlfc_cfg (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [mlfc_pkg::PADDR_W-1:0]  paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [7:0]                    report_code
);
    import mlfc_pkg::*;

    logic [7:0] code_reg;
    logic [7:0] code_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_REPORT_MODE);

    always_comb begin
        code_next = code_reg;
        if (wr_en) begin
            code_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= 8'h00;
        end else begin
            code_reg <= code_next;
        end
    end

    assign prdata      = (paddr[2] == REG_REPORT_MODE) ? {24'h000000, code_reg} : 32'h0;
    assign report_code = code_reg;

endmodule

`default_nettype wire

// ----- sv/mlfc_rx.sv -----
// request decode, reply capture and running crc check; builds up to one group per word
// depends on mlfc_pkg
`default_nettype none

module mlfc_rx #(
    parameter int unsigned REPLY_LENGTH = mlfc_pkg::REPLY_LENGTH_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               accept,
    input  wire  [1:0]        req_type,
    input  wire  [7:0]        dev_address,
    input  wire  [7:0]        drive_mode,
    input  wire  [15:0]       drive_level,
    input  wire  [7:0]        rx_byte,
    input  wire  [7:0]        report_code,
    output logic              grp_load,
    output mlfc_pkg::grp_t    grp
);
    import mlfc_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(REPLY_LENGTH - 1);

    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       bytes_reg  [STORE_DEPTH];
    logic [7:0]       bytes_next [STORE_DEPTH];
    logic [7:0]       crc_fed;
    logic             has_result;

    assign crc_fed = crc8_feed(crc_reg, rx_byte);

    always_comb begin
        pending_next  = pending_reg;
        rx_count_next = rx_count_reg;
        crc_next      = crc_reg;
        bytes_next    = bytes_reg;
        has_result    = 1'b0;
        grp           = '0;
        grp.kind      = KIND_TX;
        if (accept) begin
            unique case (req_t'(req_type))
                REQ_CMD: begin
                    has_result    = 1'b1;
                    grp.kind      = KIND_TX;
                    grp.addr      = dev_address;
                    grp.mode      = drive_mode;
                    grp.qty_lo    = drive_level[7:0];
                    grp.qty_hi    = drive_level[15:8];
                    rx_count_next = '0;
                    crc_next      = 8'h00;
                    for (int i = 0; i < STORE_DEPTH; i++) begin
                        bytes_next[i] = 8'h00;
                    end
                    pending_next  = (drive_mode == report_code);
                end
                REQ_BYTE: begin
                    if (pending_reg) begin
                        if (rx_count_reg < LAST_CNT) begin
                            for (int i = 0; i < STORE_DEPTH; i++) begin
                                if (rx_count_reg == CNT_W'(i)) begin
                                    bytes_next[i] = rx_byte;
                                end
                            end
                            crc_next      = crc_fed;
                            rx_count_next = rx_count_reg + CNT_W'(1);
                        end else begin
                            has_result    = 1'b1;
                            pending_next  = 1'b0;
                            rx_count_next = '0;
                            if (crc_reg == rx_byte) begin
                                grp.kind    = KIND_OK;
                                grp.status  = bytes_reg[1];
                                grp.current = {bytes_reg[4], bytes_reg[3]};
                                grp.speed   = {bytes_reg[6], bytes_reg[5]};
                                grp.angle   = {bytes_reg[8], bytes_reg[7]};
                            end else begin
                                grp.kind    = KIND_CRC_ERR;
                            end
                        end
                    end
                end
                REQ_TIMEOUT: begin
                    if (pending_reg) begin
                        has_result    = 1'b1;
                        grp.kind      = KIND_LEN_ERR;
                        pending_next  = 1'b0;
                        rx_count_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign grp_load = has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= 1'b0;
            rx_count_reg <= '0;
            crc_reg      <= 8'h00;
        end else begin
            pending_reg  <= pending_next;
            rx_count_reg <= rx_count_next;
            crc_reg      <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
    end

    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !pending_reg |-> rx_count_reg == '0)
        else $error("byte count nonzero with no reply pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= LAST_CNT)
        else $error("byte count beyond reply length");

    a_cmd_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_load && grp.kind == KIND_TX |=> rx_count_reg == '0 && crc_reg == 8'h00)
        else $error("command did not restart reply capture");

endmodule

`default_nettype wire

// ----- sv/mlfc_tx.sv -----
// result register and frame serializer; appends the crc-8 of the four frame bytes
// depends on mlfc_pkg
`default_nettype none

module mlfc_tx (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                grp_load,
    input  mlfc_pkg::grp_t     grp,
    output logic               load_ok,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [1:0]         m_result_kind,
    output logic [7:0]         m_tx_byte,
    output logic               m_last_of_run,
    output logic [7:0]         m_motor_status,
    output logic signed [15:0] m_current_raw,
    output logic [15:0]        m_motor_speed,
    output logic [15:0]        m_angle_raw
);
    import mlfc_pkg::*;

    logic             valid_reg, valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    grp_t             grp_reg, grp_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       sel_byte;
    logic             take;
    logic             at_last;

    assign take    = valid_reg && m_ready;
    assign at_last = (grp_reg.kind != KIND_TX) || (idx_reg == FRAME_LAST);
    assign load_ok = !valid_reg || (m_ready && at_last);

    always_comb begin
        unique case (idx_reg)
            3'd0:    sel_byte = grp_reg.addr;
            3'd1:    sel_byte = grp_reg.mode;
            3'd2:    sel_byte = grp_reg.qty_lo;
            3'd3:    sel_byte = grp_reg.qty_hi;
            default: sel_byte = crc_reg;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        grp_next   = grp_reg;
        crc_next   = crc_reg;
        if (grp_load) begin
            valid_next = 1'b1;
            idx_next   = '0;
            grp_next   = grp;
            crc_next   = 8'h00;
        end else if (take) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
                crc_next = crc8_feed(crc_reg, sel_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
        crc_reg <= crc_next;
    end

    assign m_valid        = valid_reg;
    assign m_result_kind  = grp_reg.kind;
    assign m_tx_byte      = (grp_reg.kind == KIND_TX) ? sel_byte : 8'h00;
    assign m_last_of_run  = at_last;
    assign m_motor_status = grp_reg.status;
    assign m_current_raw  = $signed(grp_reg.current);
    assign m_motor_speed  = grp_reg.speed;
    assign m_angle_raw    = grp_reg.angle;

    a_idx_only_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && idx_reg != '0 |-> grp_reg.kind == KIND_TX)
        else $error("word index advanced on a single-word result");

    a_report_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && grp_reg.kind != KIND_OK |-> grp_reg.status == 8'h00
            && grp_reg.current == 16'h0 && grp_reg.speed == 16'h0 && grp_reg.angle == 16'h0)
        else $error("report fields set outside a report");

    a_idx_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !at_last |=> valid_reg && idx_reg == $past(idx_reg) + IDX_W'(1))
        else $error("frame word index did not advance");

endmodule

`default_nettype wire

// ----- sv/motor_link_frame_codec.sv -----
// motor link frame codec top level: command framing and report checking
// depends on mlfc_pkg, mlfc_cfg, mlfc_rx, mlfc_tx
//
// s_ channel takes one request word: a command, a received byte or a timeout.
// m_ channel gives result words: a command yields five transmit bytes (address,
// mode, quantity low, quantity high, crc-8), the last with m_last_of_run set.
// the final byte of a report reply yields one report or crc error word; a
// timeout during a reply yields one length error word; other requests yield none.
// the first result word appears in the cycle after its request is taken; a
// request is taken every cycle as long as results are taken. a command holds
// the result register until its five frame bytes have left, one byte per cycle
// while m_ready is high, and the next request is taken as its last byte is.
// when the receiver stalls, the result register holds and s_ready stays low
// while a word waits in it.
// reset clears the pending reply, byte count, running crc and the report
// mode code; the result register comes up empty.
`default_nettype none

module motor_link_frame_codec #(
    parameter int unsigned REPLY_LENGTH = mlfc_pkg::REPLY_LENGTH_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [mlfc_pkg::PADDR_W-1:0]  paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [1:0]                    s_req_type,
    input  wire  [7:0]                    s_dev_address,
    input  wire  [7:0]                    s_drive_mode,
    input  wire  [15:0]                   s_drive_level,
    input  wire  [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [1:0]                    m_result_kind,
    output logic [7:0]                    m_tx_byte,
    output logic                          m_last_of_run,
    output logic [7:0]                    m_motor_status,
    output logic signed [15:0]            m_current_raw,
    output logic [15:0]                   m_motor_speed,
    output logic [15:0]                   m_angle_raw
);
    import mlfc_pkg::*;

    logic [7:0] report_code;
    logic       accept;
    logic       grp_load;
    grp_t       grp;
    logic       load_ok;

    assign s_ready = load_ok;
    assign accept  = s_valid && s_ready;

    mlfc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .report_code (report_code)
    );

    mlfc_rx #(
        .REPLY_LENGTH (REPLY_LENGTH)
    ) u_rx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .req_type    (s_req_type),
        .dev_address (s_dev_address),
        .drive_mode  (s_drive_mode),
        .drive_level (s_drive_level),
        .rx_byte     (s_rx_byte),
        .report_code (report_code),
        .grp_load    (grp_load),
        .grp         (grp)
    );

    mlfc_tx u_tx (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .grp_load       (grp_load),
        .grp            (grp),
        .load_ok        (load_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_tx_byte      (m_tx_byte),
        .m_last_of_run  (m_last_of_run),
        .m_motor_status (m_motor_status),
        .m_current_raw  (m_current_raw),
        .m_motor_speed  (m_motor_speed),
        .m_angle_raw    (m_angle_raw)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for motor_link_frame_codec: command frames, report replies,
// crc and length errors, driven through random idling on both word channels
// depends on mlfc_pkg and the motor_link_frame_codec rtl

module testbench;

    import mlfc_pkg::*;

    localparam int unsigned REPLY_LEN = REPLY_LENGTH_DEF;
    localparam int unsigned STORE_N = STORE_DEPTH;
    localparam logic [7:0] POLY = 8'h07;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] REPORT_MODE_ADDR = 3'd0;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  addr;
        logic [7:0]  mode;
        logic [15:0] qty;
        logic [7:0]  rxb;
    } link_req_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx;
        logic        last;
        logic [7:0]  status;
        logic [15:0] current;
        logic [15:0] speed;
        logic [15:0] angle;
    } link_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [7:0] s_dev_address = '0;
    logic [7:0] s_drive_mode = '0;
    logic [15:0] s_drive_level = '0;
    logic [7:0] s_rx_byte = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_result_kind;
    logic [7:0] m_tx_byte;
    logic m_last_of_run;
    logic [7:0] m_motor_status;
    logic signed [15:0] m_current_raw;
    logic [15:0] m_motor_speed;
    logic [15:0] m_angle_raw;

    link_req_t pending_items[$];
    link_word_t expected_words[$];
    link_req_t cur_item;
    link_word_t got_word;
    logic in_done = 1'b0;
    logic no_idle = 1'b0;
    int s_gap = 0;
    int m_stall = 0;
    int n_errors = 0;
    int stuck_cycles = 0;
    logic [7:0] gen_code = 8'h00;

    // predictor state
    logic [7:0] report_code_seen = 8'h00;
    logic reply_wait = 1'b0;
    logic [3:0] rx_cnt = '0;
    logic [7:0] rx_crc = 8'h00;
    logic [7:0] reply_store [STORE_N];

    motor_link_frame_codec u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_dev_address(s_dev_address),
        .s_drive_mode(s_drive_mode),
        .s_drive_level(s_drive_level),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_kind(m_result_kind),
        .m_tx_byte(m_tx_byte),
        .m_last_of_run(m_last_of_run),
        .m_motor_status(m_motor_status),
        .m_current_raw(m_current_raw),
        .m_motor_speed(m_motor_speed),
        .m_angle_raw(m_angle_raw)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        repeat (8) c = (c << 1) ^ (c[7] ? POLY : 8'h00);
        return c;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (n_errors < 100) begin
            $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
        end
        n_errors++;
    endtask

    task automatic push_item(input logic [1:0] req, input logic [7:0] addr,
                             input logic [7:0] mode, input logic [15:0] qty,
                             input logic [7:0] rxb);
        link_req_t it;
        it.req = req;
        it.addr = addr;
        it.mode = mode;
        it.qty = qty;
        it.rxb = rxb;
        pending_items = {pending_items, it};
    endtask

    task automatic push_cmd(input logic [7:0] addr, input logic [7:0] mode,
                            input logic [15:0] qty);
        push_item(REQ_CMD, addr, mode, qty, 8'($urandom));
    endtask

    task automatic push_rx(input logic [7:0] b);
        push_item(REQ_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), b);
    endtask

    task automatic push_timeout_noise();
        push_item(REQ_TIMEOUT, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // body bytes first, then their crc xor flip as the closing byte
    task automatic push_reply(input logic [8*(REPLY_LEN-1)-1:0] body, input logic [7:0] flip);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < REPLY_LEN - 1; i++) begin
            acc = crc_next(acc, body[8*i +: 8]);
            push_rx(body[8*i +: 8]);
        end
        push_rx(acc ^ flip);
    endtask

    task automatic predict_codec(input link_req_t w);
        logic [39:0] frame;
        logic [7:0] acc;
        link_word_t r;
        int i;
        case (w.req)
            REQ_CMD: begin
                frame[31:0] = {w.qty[15:8], w.qty[7:0], w.mode, w.addr};
                acc = 8'h00;
                for (i = 0; i < 4; i++) acc = crc_next(acc, frame[8*i +: 8]);
                frame[39:32] = acc;
                for (i = 0; i < 5; i++) begin
                    r = '0;
                    r.kind = KIND_TX;
                    r.tx = frame[8*i +: 8];
                    r.last = (i == 4);
                    expected_words = {expected_words, r};
                end
                rx_cnt = '0;
                rx_crc = 8'h00;
                for (i = 0; i < STORE_N; i++) reply_store[i] = 8'h00;
                reply_wait = (w.mode == report_code_seen);
            end
            REQ_BYTE: begin
                if (reply_wait) begin
                    if (rx_cnt < REPLY_LEN - 1) begin
                        if (rx_cnt < STORE_N) reply_store[rx_cnt] = w.rxb;
                        rx_crc = crc_next(rx_crc, w.rxb);
                        rx_cnt = rx_cnt + 1'b1;
                    end else begin
                        reply_wait = 1'b0;
                        rx_cnt = '0;
                        r = '0;
                        r.last = 1'b1;
                        if (rx_crc == w.rxb) begin
                            r.kind = KIND_OK;
                            r.status = reply_store[1];
                            r.current = {reply_store[4], reply_store[3]};
                            r.speed = {reply_store[6], reply_store[5]};
                            r.angle = {reply_store[8], reply_store[7]};
                        end else begin
                            r.kind = KIND_CRC_ERR;
                        end
                        expected_words = {expected_words, r};
                    end
                end
            end
            REQ_TIMEOUT: begin
                if (reply_wait) begin
                    reply_wait = 1'b0;
                    rx_cnt = '0;
                    r = '0;
                    r.kind = KIND_LEN_ERR;
                    r.last = 1'b1;
                    expected_words = {expected_words, r};
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic write_report_mode(input logic [7:0] code);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REPORT_MODE_ADDR;
        pwdata <= ($urandom & 32'hFFFF_FF00) | code;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gen_code = code;
    endtask

    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_items.size() != 0 || s_valid || expected_words.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // mostly well-formed report exchanges with random content, some broken, some noise
    task automatic random_traffic(input int target);
        int counted;
        int pick;
        int k;
        logic [8*(REPLY_LEN-1)-1:0] body;
        logic [7:0] m;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            body = 72'({$urandom, $urandom, $urandom});
            if (pick < 70) begin
                push_cmd(8'($urandom), gen_code, 16'($urandom));
                counted++;
                if (pick < 40) begin
                    push_reply(body, 8'h00);
                    counted += REPLY_LEN;
                end else if (pick < 50) begin
                    push_reply(body, 8'($urandom_range(1, 255)));
                    counted += REPLY_LEN;
                end else begin
                    k = $urandom_range(0, REPLY_LEN - 1);
                    for (int i = 0; i < k; i++) push_rx(8'($urandom));
                    counted += k;
                    if (pick < 60) begin
                        push_timeout_noise();
                        counted++;
                    end
                end
            end else if (pick < 80) begin
                m = 8'($urandom);
                if (m == gen_code) m = ~m;
                push_cmd(8'($urandom), m, 16'($urandom));
                counted++;
                k = $urandom_range(0, 2);
                for (int i = 0; i < k; i++) push_rx(8'($urandom));
            end else if (pick < 90) begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++) begin
                    case ($urandom_range(0, 2))
                        0: push_rx(8'($urandom));
                        1: push_timeout_noise();
                        default: push_item(REQ_UNUSED, 8'($urandom), 8'($urandom),
                                           16'($urandom), 8'($urandom));
                    endcase
                end
            end else begin
                push_cmd(8'($urandom), gen_code, 16'($urandom));
                for (int i = 0; i < REPLY_LEN; i++) push_rx(8'($urandom));
                counted += REPLY_LEN + 1;
            end
        end
    endtask

    // input side: acceptance, prediction and register shadow
    always @(posedge aclk) begin
        if (!aresetn) begin
            report_code_seen = 8'h00;
            reply_wait = 1'b0;
            rx_cnt = '0;
            rx_crc = 8'h00;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REPORT_MODE_ADDR) begin
                report_code_seen = pwdata[7:0];
            end
            if (s_valid && s_ready) begin
                predict_codec(cur_item);
                in_done = 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_done) begin
            in_done = 1'b0;
            if (s_gap > 0 && !no_idle) begin
                s_gap = s_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                cur_item = pending_items.pop_front();
                s_req_type <= cur_item.req;
                s_dev_address <= cur_item.addr;
                s_drive_mode <= cur_item.mode;
                s_drive_level <= cur_item.qty;
                s_rx_byte <= cur_item.rxb;
                s_valid <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) s_gap = $urandom_range(1, 13);
            end
        end
    end

    always @(negedge aclk) begin
        if (no_idle || !aresetn) begin
            m_stall = 0;
            m_ready <= 1'b1;
        end else if (m_stall > 0) begin
            m_stall = m_stall - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) m_stall = $urandom_range(1, 13);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word kind", m_result_kind, 0);
            end else begin
                got_word = expected_words.pop_front();
                if (m_result_kind !== got_word.kind)
                    report_mismatch("kind", m_result_kind, got_word.kind);
                if (m_tx_byte !== got_word.tx)
                    report_mismatch("tx_byte", m_tx_byte, got_word.tx);
                if (m_last_of_run !== got_word.last)
                    report_mismatch("last_of_run", m_last_of_run, got_word.last);
                if (m_motor_status !== got_word.status)
                    report_mismatch("motor_status", m_motor_status, got_word.status);
                if (m_current_raw !== got_word.current)
                    report_mismatch("current_raw", m_current_raw, got_word.current);
                if (m_motor_speed !== got_word.speed)
                    report_mismatch("motor_speed", m_motor_speed, got_word.speed);
                if (m_angle_raw !== got_word.angle)
                    report_mismatch("angle_raw", m_angle_raw, got_word.angle);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        write_report_mode(8'hA5);
        // idle byte, idle timeout, unused request type
        push_rx(8'hFF);
        push_item(REQ_TIMEOUT, 8'h00, 8'h00, 16'h0000, 8'h00);
        push_item(REQ_UNUSED, 8'hFF, 8'hA5, 16'hFFFF, 8'hFF);
        // non-report command, then report with a good reply at field extremes
        push_cmd(8'h00, 8'h00, 16'h0000);
        push_cmd(8'hFF, 8'hA5, 16'hFFFF);
        push_reply(72'h7F_FF_FF_FF_80_00_00_FF_00, 8'h00);
        // short reply ended by timeout
        push_cmd(8'h5A, 8'hA5, 16'h1234);
        push_rx(8'h01);
        push_rx(8'hFE);
        push_item(REQ_TIMEOUT, 8'h00, 8'h00, 16'h0000, 8'h00);
        // partial reply flushed by a non-report command, later bytes dropped
        push_cmd(8'h01, 8'hA5, 16'h8000);
        push_rx(8'h55);
        push_cmd(8'h02, 8'h7E, 16'h00FF);
        push_rx(8'hAA);
        push_item(REQ_TIMEOUT, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        wait_idle();

        write_report_mode(8'h00);
        random_traffic(80);
        wait_idle();

        write_report_mode(8'hFF);
        random_traffic(80);
        wait_idle();

        write_report_mode(8'($urandom));
        random_traffic(70);
        wait_idle();

        no_idle = 1'b1;
        write_report_mode(8'($urandom));
        random_traffic(70);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (expected_words.size() != 0) begin
            report_mismatch("words never seen", expected_words.size(), 0);
        end
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
